### rtl/sfm_pkg.sv
package sfm_pkg;
  localparam int EXP_BITS  = 8;
  localparam int FRAC_BITS = 23;
  localparam int EXP_BIAS  = 127;
  localparam int MANT_BITS = FRAC_BITS + 1;
  localparam int PROD_BITS = 2 * MANT_BITS;
  localparam int EXPW      = EXP_BITS + 2;
  localparam logic signed [EXPW-1:0] EXP_MAX = EXPW'(254);

  typedef struct packed {
    logic                   sign;
    logic signed [EXPW-1:0] ex;
    logic [PROD_BITS-1:0]   prod;
  } sfm_mul_t;
endpackage

### rtl/sfm_mul_stage.sv
module sfm_mul_stage
  import sfm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          in_operand_a,
  input  logic [31:0]          in_operand_b,
  output logic                 s2_valid,
  input  logic                 s2_ready,
  output sfm_mul_t             s2_data
);
  logic                 s1_valid_r;
  logic                 s1_sign_r;
  logic signed [EXPW-1:0] s1_ex_r;
  logic [MANT_BITS-1:0] s1_ma_r, s1_mb_r;
  logic                 s2_valid_r;
  sfm_mul_t             s2_data_r;
  logic                 s1_ready, s2_adv;

  assign s2_adv   = !s2_valid_r || s2_ready;
  assign s1_ready = !s1_valid_r || s2_adv;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_valid;
      if (s2_adv) s2_valid_r <= s1_valid_r;
    end
    if (s1_ready && in_valid) begin
      s1_sign_r <= in_operand_a[31] ^ in_operand_b[31];
      s1_ex_r   <= EXPW'(in_operand_a[30:23]) + EXPW'(in_operand_b[30:23])
                   - EXPW'(EXP_BIAS);
      s1_ma_r   <= {1'b1, in_operand_a[FRAC_BITS-1:0]};
      s1_mb_r   <= {1'b1, in_operand_b[FRAC_BITS-1:0]};
    end
    if (s2_adv && s1_valid_r) begin
      s2_data_r.sign <= s1_sign_r;
      s2_data_r.ex   <= s1_ex_r;
      s2_data_r.prod <= PROD_BITS'(s1_ma_r) * PROD_BITS'(s1_mb_r);
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_data  = s2_data_r;
endmodule

### rtl/sfm_norm_stage.sv
module sfm_norm_stage
  import sfm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s2_valid,
  output logic        s2_ready,
  input  sfm_mul_t    s2_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_product_bits,
  output logic        out_exponent_out_of_range
);
  logic                   out_valid_r;
  logic [31:0]            bits_r;
  logic                   oor_r;
  logic                   top;
  logic [MANT_BITS:0]     m_sel;
  logic [MANT_BITS:0]     m_rnd;
  logic signed [EXPW-1:0] ex_nxt;
  logic [FRAC_BITS-1:0]   frac;

  always_comb begin
    top   = s2_data.prod[PROD_BITS-1];
    m_sel = top ? s2_data.prod[PROD_BITS-1 -: MANT_BITS+1]
                : s2_data.prod[PROD_BITS-2 -: MANT_BITS+1];
    m_rnd = {1'b0, m_sel[MANT_BITS:1]} + (MANT_BITS+1)'(m_sel[0]);
    // rounding carry into 2.0 leaves a zero fraction
    ex_nxt = s2_data.ex + EXPW'(top) + EXPW'(m_rnd[MANT_BITS]);
    frac   = m_rnd[MANT_BITS] ? '0 : m_rnd[FRAC_BITS-1:0];
  end

  assign s2_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (s2_ready) out_valid_r <= s2_valid;
    if (s2_ready && s2_valid) begin
      bits_r <= {s2_data.sign, ex_nxt[EXP_BITS-1:0], frac};
      oor_r  <= (ex_nxt < EXPW'(1)) || (ex_nxt > EXP_MAX);
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_product_bits          = bits_r;
  assign out_exponent_out_of_range = oor_r;
endmodule

### rtl/single_float_multiply.sv
// Single-precision multiplier, three register stages.
// Input channel: in_valid/in_ready with in_operand_a and in_operand_b,
// both normalized single-precision patterns (no special-value handling).
// Result channel: out_valid/out_ready with out_product_bits and
// out_exponent_out_of_range (biased exponent outside 1..254; the low
// 8 bits of the exponent are kept in the pattern).
// Throughput: one pair per cycle while out_ready is high; stage 1
// decodes and adds exponents, stage 2 holds the 24x24 mantissa product,
// stage 3 normalizes and rounds half up on the first dropped bit.
// Reset (rst_n low, synchronous) empties every stage.
// When the receiver stalls, each stage holds its item and ready drops
// stage by stage, so nothing is lost or repeated; a bubble in any stage
// is filled while the output waits.
module single_float_multiply
  import sfm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_product_bits,
  output logic        out_exponent_out_of_range
);
  logic     s2_valid, s2_ready;
  sfm_mul_t s2_data;

  sfm_mul_stage u_mul (
    .clk, .rst_n, .in_valid, .in_ready, .in_operand_a, .in_operand_b,
    .s2_valid, .s2_ready, .s2_data
  );

  sfm_norm_stage u_norm (
    .clk, .rst_n, .s2_valid, .s2_ready, .s2_data,
    .out_valid, .out_ready, .out_product_bits, .out_exponent_out_of_range
  );
endmodule

### rtl/sfm_checker.sv
module sfm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_product_bits,
  input logic        out_exponent_out_of_range
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_product_bits)
      && $stable(out_exponent_out_of_range))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing after three cycles");
endmodule

bind single_float_multiply sfm_checker u_sfm_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_product_bits, .out_exponent_out_of_range
);

### bench/tb_single_float_multiply.sv
`timescale 1ns / 100ps

class product_scoreboard;
  bit [31:0] pending_bits[$];
  bit        pending_oor[$];
  int        mismatches;

  // Multiply two single-precision patterns the way the block does.
  function automatic void predict(input bit [31:0] a, input bit [31:0] b,
                                  output bit [31:0] bits, output bit oor);
    bit              sgn;
    int              ex;
    bit [47:0]       prod;
    bit [24:0]       m;
    bit              top;
    sgn  = a[31] ^ b[31];
    ex   = int'(a[30:23]) + int'(b[30:23]) - sfm_pkg::EXP_BIAS;
    prod = {24'd0, 1'b1, a[22:0]} * {24'd0, 1'b1, b[22:0]};
    top  = prod[47];
    ex  += top;
    m    = top ? prod[47:23] : prod[46:22];
    m    = (m >> 1) + m[0];
    // round carry reached 2.0
    if (m[24]) begin
      m  = m >> 1;
      ex += 1;
    end
    oor  = (ex < 1) || (ex > 254);
    bits = {sgn, 8'(ex), m[22:0]};
  endfunction

  function void note_operands(bit [31:0] a, bit [31:0] b);
    bit [31:0] bits;
    bit        oor;
    predict(a, b, bits, oor);
    pending_bits.push_back(bits);
    pending_oor.push_back(oor);
  endfunction

  function void check_product(bit [31:0] bits, bit oor);
    bit [31:0] exp_bits;
    bit        exp_oor;
    if (pending_bits.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected product %h oor %b", bits, oor);
      return;
    end
    exp_bits = pending_bits.pop_front();
    exp_oor  = pending_oor.pop_front();
    if (bits !== exp_bits || oor !== exp_oor) begin
      mismatches++;
      if (mismatches <= 10)
        $display("product mismatch: expected %h/%b got %h/%b", exp_bits, exp_oor, bits, oor);
    end
  endfunction
endclass

module tb_single_float_multiply;
  import sfm_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [31:0] in_operand_a = 0;
  logic [31:0] in_operand_b = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] out_product_bits;
  logic        out_exponent_out_of_range;

  product_scoreboard board = new();
  bit  sending_done = 0;
  bit  quiet_phase = 0;
  bit  long_holdoff = 0;

  single_float_multiply dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) board.note_operands(in_operand_a, in_operand_b);
    if (rst_n && out_valid && out_ready)
      board.check_product(out_product_bits, out_exponent_out_of_range);
  end

  // Drive one pair; optional gap first.
  task automatic send_pair(input bit [31:0] a, input bit [31:0] b);
    int gap;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 0;
    @(posedge clk);
    while (board.pending_bits.size() != 0) @(posedge clk);
  endtask

  function automatic bit [31:0] random_normal();
    bit [31:0] v;
    v = $urandom();
    // mostly mid-range exponents, some extremes
    if ($urandom_range(0, 3) != 0) v[30:23] = $urandom_range(64, 190);
    return v;
  endfunction

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      if (long_holdoff) begin
        out_ready <= 0;
        repeat (60) @(posedge clk);
        long_holdoff = 0;
      end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        out_ready <= 0;
        stall = $urandom_range(1, 9);
        repeat (stall) @(posedge clk);
      end else begin
        out_ready <= 1;
        @(posedge clk);
      end
    end
  end

  initial begin
    bit [31:0] corner[12];
    corner = '{32'h3F800000, 32'h7F7FFFFF, 32'h00000000, 32'hFFFFFFFF,
               32'h80000000, 32'h7F800000, 32'h00800000, 32'h3FFFFFFF,
               32'h3FB504F3, 32'h40000000, 32'hBF800001, 32'h007FFFFF};
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (corner[i]) send_pair(corner[i], corner[(i * 5 + 3) % 12]);
    send_pair(32'h3FFFFFFF, 32'h3FFFFFFF);  // largest mantissa squared, no rounding carry
    send_pair(32'h7F000000, 32'h7F000000);  // overflow
    send_pair(32'h00800000, 32'h00800000);  // underflow
    send_pair(32'h3F800000, 32'hBF800000);
    drain();
    long_holdoff = 1;
    for (int i = 0; i < 1200; i++) begin
      if (i == 600) drain();
      if (i == 1000) quiet_phase = 1;
      send_pair(($urandom_range(0, 9) == 0) ? $urandom() : random_normal(),
                ($urandom_range(0, 9) == 0) ? $urandom() : random_normal());
    end
    drain();
    repeat (10) @(posedge clk);
    if (board.mismatches == 0 && board.pending_bits.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
